@@ sv/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and sizes for the bitmap slot allocator: request and response
// words, operation and status codes, occupancy row geometry.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int DATA_BITS = 64;

    // field widths of the request and response words
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 10;
    localparam int NDATA_W  = 64;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 11;
    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    localparam int SLOT_AW  = $clog2(MAX_SLOTS);
    // occupancy is kept in rows, one row-full flag per row
    localparam int ROW_BITS = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
    localparam int NUM_ROWS = MAX_SLOTS / ROW_BITS;
    localparam int ROW_AW   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int BIT_AW   = $clog2(ROW_BITS);
    // the first-free encoder serves both the row flags and one row
    localparam int ENC_W    = (ROW_BITS > NUM_ROWS) ? ROW_BITS : NUM_ROWS;
    localparam int ENC_AW   = $clog2(ENC_W);
    // compare width, covers node_count and any slot number
    localparam int CMP_W    = 17;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC    = 3'd0,
        ACT_REGISTER = 3'd1,
        ACT_FREE     = 3'd2,
        ACT_READ     = 3'd3,
        ACT_MODIFY   = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_ALREADY   = 3'd3,
        ST_NO_FREE   = 3'd4
    } t_status;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  slot_index;
        logic [NDATA_W-1:0]  node_data;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  result_index;
        logic [NDATA_W-1:0]  result_data;
    } t_rsp;

    typedef struct packed {
        logic              found;
        logic [ENC_AW-1:0] pos;
    } t_ff_res;

endpackage

@@ sv/bsa_ram.sv @@
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/bsa_first_free.sv @@
// ----------------------------------------------------------------------------
// bsa_first_free
// Lowest-zero encoder, shared between the row-full flags and one
// occupancy row.
// ----------------------------------------------------------------------------
module bsa_first_free (
    input  logic [bsa_pkg::ENC_W-1:0] i_bits,
    output bsa_pkg::t_ff_res          o_res
);
    import bsa_pkg::*;

    always_comb begin
        o_res = '0;
        for (int i = ENC_W - 1; i >= 0; i--) begin
            if (!i_bits[i]) begin
                o_res.found = 1'b1;
                o_res.pos   = ENC_AW'(i);
            end
        end
    end

endmodule

@@ sv/bitmap_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_unit
// Slot store with occupancy bitmap: allocate lowest free, register, free,
// read and modify, driven by a small sequencer around one first-free encoder.
// ----------------------------------------------------------------------------
// Sequence: accept, lookup, execute, hand-off, one request at a time; the
// hand-off waits while the last result is unaccepted. The lookup step holds
// the occupancy row read between the row search and the bit search.
// Reset: synchronous; after reset a clearing pass zeroes the data store and
// the occupancy rows, one slot per cycle over all MAX_SLOTS (1024) slots,
// with no request accepted meanwhile. node_count resets to 1024.
module bitmap_slot_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bsa_pkg::t_req                i_req,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bsa_pkg::t_rsp                o_rsp,
    input  logic                         i_cfg_we,
    input  logic [bsa_pkg::CNT_W-1:0]    i_cfg_wdata
);
    import bsa_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_EXEC  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    t_req                r_req;
    t_rsp                r_pend, n_pend;
    t_rsp                r_out;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_node_count;
    logic [SLOT_AW-1:0]  r_clr_cnt;
    logic [NUM_ROWS-1:0] r_full;
    logic [ROW_AW-1:0]   r_row;
    logic                r_row_found;

    logic [ENC_W-1:0]    enc_in;
    t_ff_res             ff;

    logic                occ_we;
    logic [ROW_AW-1:0]   occ_waddr, occ_raddr;
    logic [ROW_BITS-1:0] occ_wdata, occ_rdata;
    logic                dat_we;
    logic [SLOT_AW-1:0]  dat_waddr;
    logic [DATA_BITS-1:0] dat_wdata, dat_rdata;

    logic [CMP_W-1:0]    idx_ext, alloc_ext;
    logic [ROW_AW-1:0]   idx_row;
    logic [BIT_AW-1:0]   idx_bit, alloc_bit;
    logic                accept, out_load;

    function automatic logic in_range(input logic [CMP_W-1:0] v,
                                      input logic [CNT_W-1:0] cnt);
        in_range = (v < CMP_W'(cnt)) && (v < CMP_W'(MAX_SLOTS));
    endfunction

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign idx_ext   = CMP_W'(r_req.slot_index);
    assign idx_row   = ROW_AW'(idx_ext >> BIT_AW);
    assign idx_bit   = BIT_AW'(idx_ext);
    assign alloc_bit = BIT_AW'(ff.pos);
    assign alloc_ext = (CMP_W'(r_row) << BIT_AW) | CMP_W'(alloc_bit);

    // encoder looks at row flags while searching rows, at the row word after
    always_comb begin
        enc_in = '1;
        if (r_state == S_EXEC) begin
            enc_in[ROW_BITS-1:0] = occ_rdata;
        end else begin
            enc_in[NUM_ROWS-1:0] = r_full;
        end
    end

    bsa_first_free u_first_free (
        .i_bits (enc_in),
        .o_res  (ff)
    );

    assign occ_raddr = (r_req.action == ACT_ALLOC) ? ROW_AW'(ff.pos) : idx_row;

    bsa_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_ROWS)) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_raddr (occ_raddr),
        .o_rdata (occ_rdata)
    );

    bsa_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_SLOTS)) u_dat_ram (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (dat_wdata),
        .i_raddr (SLOT_AW'(idx_ext)),
        .o_rdata (dat_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        occ_we    = 1'b0;
        occ_waddr = idx_row;
        occ_wdata = occ_rdata;
        dat_we    = 1'b0;
        dat_waddr = SLOT_AW'(idx_ext);
        dat_wdata = r_req.node_data[DATA_BITS-1:0];
        unique case (r_state)
            S_CLEAR: begin
                dat_we    = 1'b1;
                dat_waddr = r_clr_cnt;
                dat_wdata = '0;
                occ_we    = (CMP_W'(r_clr_cnt) < CMP_W'(NUM_ROWS));
                occ_waddr = ROW_AW'(r_clr_cnt);
                occ_wdata = '0;
                if (CMP_W'(r_clr_cnt) == CMP_W'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                n_pend  = '0;
                n_pend.status = ST_OK;
                unique case (r_req.action)
                    ACT_ALLOC: begin
                        if (!r_row_found || !ff.found || !in_range(alloc_ext, r_node_count))
                        begin
                            n_pend.status = ST_NO_FREE;
                        end else begin
                            occ_we    = 1'b1;
                            occ_waddr = r_row;
                            occ_wdata = occ_rdata | (ROW_BITS'(1) << alloc_bit);
                            dat_we    = 1'b1;
                            dat_waddr = SLOT_AW'(alloc_ext);
                            n_pend.result_index = INDEX_W'(alloc_ext);
                        end
                    end
                    ACT_REGISTER, ACT_FREE, ACT_READ, ACT_MODIFY: begin
                        // index check comes before the occupancy check
                        if (!in_range(idx_ext, r_node_count)) begin
                            n_pend.status = ST_BAD_INDEX;
                        end else if (r_req.action == ACT_REGISTER) begin
                            if (occ_rdata[idx_bit]) begin
                                n_pend.status = ST_ALREADY;
                            end else begin
                                occ_we    = 1'b1;
                                occ_wdata = occ_rdata | (ROW_BITS'(1) << idx_bit);
                            end
                        end else if (!occ_rdata[idx_bit]) begin
                            n_pend.status = ST_NOT_ALLOC;
                        end else if (r_req.action == ACT_FREE) begin
                            occ_we    = 1'b1;
                            occ_wdata = occ_rdata & ~(ROW_BITS'(1) << idx_bit);
                        end else if (r_req.action == ACT_READ) begin
                            n_pend.result_data = NDATA_W'(dat_rdata);
                        end else begin
                            dat_we = 1'b1;
                        end
                    end
                    default: begin
                        // unknown action: no change, plain ok word
                    end
                endcase
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_cnt    <= '0;
            r_full       <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= CNT_RESET;
            r_row_found  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + SLOT_AW'(1);
            end
            if (i_cfg_we) begin
                r_node_count <= i_cfg_wdata;
            end
            if (r_state == S_LOOK) begin
                r_row_found <= ff.found;
            end
            if (occ_we && (r_state == S_EXEC)) begin
                r_full[occ_waddr] <= &occ_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (r_state == S_LOOK) begin
            r_row <= ROW_AW'(ff.pos);
        end
        r_pend <= n_pend;
        if (out_load) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_out;

    // a row not flagged full must hold a free bit
    a_row_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_req.action == ACT_ALLOC && r_row_found) |-> ff.found)
        else $error("row flagged not full has no free bit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("request accepted while sequencer busy");

    a_no_word_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_out_valid && !o_in_ready))
        else $error("handshake active during clearing pass");

endmodule
